@@ rtl/rbpr_pkg.sv @@
// Shared types, widths and state codes for the ring band power ratio block.
package rbpr_pkg;

	localparam int ROW_W     = 10;
	localparam int COL_W     = 10;
	localparam int SAMPLE_W  = 16;
	localparam int RADIUS_W  = 21;
	localparam int SUM_W     = 36;
	localparam int COUNT_W   = 21;
	localparam int RATIO_W   = 32;
	localparam int FRAC_W    = 16;
	localparam int CFG_IDX_W = 2;

	// multiplier operand widths: a sum is fed in two halves
	localparam int MUL_A_W   = SUM_W / 2;
	localparam int MUL_B_W   = COUNT_W;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int PROD_W    = SUM_W + COUNT_W;

	localparam int IMAGE_SIDE_DEF  = 1024;
	localparam int SAMPLE_BITS_DEF = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INNER  = 2'd0,
		CFG_MIDDLE = 2'd1,
		CFG_OUTER  = 2'd2
	} rbpr_cfg_idx_t;

	typedef struct packed {
		logic [ROW_W-1:0]    row;
		logic [COL_W-1:0]    col;
		logic [SAMPLE_W-1:0] sample_value;
		logic                last;
	} rbpr_in_t;

	typedef struct packed {
		logic [RATIO_W-1:0] ratio;
		logic               valid_res;
	} rbpr_out_t;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_ROW    = 11'b000_0000_0010,
		ST_COL    = 11'b000_0000_0100,
		ST_BAND   = 11'b000_0000_1000,
		ST_NUM_LO = 11'b000_0001_0000,
		ST_NUM_HI = 11'b000_0010_0000,
		ST_DEN_LO = 11'b000_0100_0000,
		ST_DEN_HI = 11'b000_1000_0000,
		ST_CHECK  = 11'b001_0000_0000,
		ST_DIV    = 11'b010_0000_0000,
		ST_DONE   = 11'b100_0000_0000
	} rbpr_state_t;

	// divider handshake
	typedef struct packed {
		logic busy;
		logic done;
	} rbpr_div_stat_t;

endpackage

@@ rtl/rbpr_mul.sv @@
// Shared multiplier: squares row and column, forms the band cross products.
module rbpr_mul
	import rbpr_pkg::*;
(
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [MUL_P_W-1:0] p
);

	assign p = MUL_P_W'(a) * MUL_P_W'(b);

endmodule

@@ rtl/rbpr_div.sv @@
// Restoring divider, one quotient bit per cycle, for the Q16.16 ratio.
module rbpr_div
	import rbpr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [PROD_W-1:0]   num,
	input  logic [PROD_W-1:0]   den,   // held stable while busy
	output rbpr_div_stat_t      stat,
	output logic [RATIO_W-1:0]  quo
);

	localparam int CNT_W = $clog2(RATIO_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RATIO_W - 1);

	logic [PROD_W-1:0]  rem_q;
	logic [RATIO_W-1:0] lo_q;
	logic [RATIO_W-1:0] quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [PROD_W:0]    shifted;
	logic               ge;

	// caller guarantees num < den * 2^16, so the quotient fits 32 bits
	// and the upper dividend part starts below den
	assign shifted = {rem_q, lo_q[RATIO_W-1]};
	assign ge      = (shifted >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {{FRAC_W{1'b0}}, num[PROD_W-1:FRAC_W]};
			lo_q  <= {num[FRAC_W-1:0], {(RATIO_W-FRAC_W){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			lo_q  <= {lo_q[RATIO_W-2:0], 1'b0};
			quo_q <= {quo_q[RATIO_W-2:0], ge};
			if (ge) begin
				rem_q <= PROD_W'(shifted - {1'b0, den});
			end else begin
				rem_q <= shifted[PROD_W-1:0];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

@@ rtl/ring_band_power_ratio_top.sv @@
// Top level of the ring band power ratio block: sequencer, band state, output register.
//
// Pixels of a power-spectrum image arrive one item at a time with their row and
// column. Each pixel's squared radius row^2+col^2 is formed on one shared 18x21
// multiplier; pixels with inner < r2 < middle add to band one, pixels with
// r2 > inner, middle <= r2 < outer add to band two (sums and counts saturate).
// Pixels with row or col at or beyond IMAGE_SIDE are skipped. A pixel item passes
// through accept, row square, column square and add, and band update; in_stall is
// high from row square through band update. On the item marked last the block
// forms sum2*cnt1 and sum1*cnt2 on the same multiplier in two 18-bit halves each,
// checks for an empty band or an out-of-range quotient, then runs a restoring
// divider at one bit per cycle and hands the quotient over; a last pixel's result
// enters the output register after that, or after the check alone when the check
// settles the ratio without dividing, and in_stall stays high until then, longer
// while out_stall holds a prior result. ratio is avg2/avg1 in unsigned Q16.16, all
// ones on overflow or a zero band one sum; valid_res is 0 (ratio 0) when either
// band is empty. Band state clears after each last pixel. The radius registers are
// written through cfg_we/cfg_index/cfg_data (0 inner, 1 middle, 2 outer); the user
// must write them only while idle, and the block itself does not enforce it.
module ring_band_power_ratio_top
	import rbpr_pkg::*;
#(
	parameter int IMAGE_SIDE  = IMAGE_SIDE_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// config
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RADIUS_W-1:0]  cfg_data,
	// pixel items
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rbpr_in_t             in_item,
	// result items
	output logic                 out_valid,
	input  logic                 out_stall,
	output rbpr_out_t            out_item
);

	localparam int SAMPLE_USE = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
		SAMPLE_W'((33'd1 << SAMPLE_USE) - 33'd1);
	localparam logic [31:0] SIDE = 32'(IMAGE_SIDE);
	localparam int HALF = MUL_A_W;

	rbpr_state_t state_q;

	// config registers
	logic [RADIUS_W-1:0] inner_q, middle_q, outer_q;

	// current pixel
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                last_q;
	logic [RADIUS_W-1:0] r2_q;

	// band state
	logic [SUM_W-1:0]   sum1_q, sum2_q;
	logic [COUNT_W-1:0] cnt1_q, cnt2_q;

	// ratio terms
	logic [PROD_W-1:0]  num_q, den_q;
	logic [RATIO_W-1:0] ratio_q;
	logic               vres_q;

	logic               out_valid_q;
	rbpr_out_t          out_item_q;

	// shared multiplier
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;

	rbpr_div_stat_t     div_stat;
	logic [RATIO_W-1:0] div_quo;
	logic               div_start;

	logic               in_acc;
	logic               out_free;
	logic               in_image;
	logic               hit1, hit2;
	logic [SUM_W:0]     sum1_nx, sum2_nx;
	logic               bands_ok;
	logic               ovf;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_ROW: begin
				mul_a = MUL_A_W'(row_q);
				mul_b = MUL_B_W'(row_q);
			end
			ST_COL: begin
				mul_a = MUL_A_W'(col_q);
				mul_b = MUL_B_W'(col_q);
			end
			ST_NUM_LO: begin
				mul_a = sum2_q[HALF-1:0];
				mul_b = cnt1_q;
			end
			ST_NUM_HI: begin
				mul_a = sum2_q[SUM_W-1:HALF];
				mul_b = cnt1_q;
			end
			ST_DEN_LO: begin
				mul_a = sum1_q[HALF-1:0];
				mul_b = cnt2_q;
			end
			ST_DEN_HI: begin
				mul_a = sum1_q[SUM_W-1:HALF];
				mul_b = cnt2_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	rbpr_mul u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (mul_p)
	);

	// band decision on the finished squared radius
	assign in_image = (32'(row_q) < SIDE) && (32'(col_q) < SIDE);
	assign hit1     = in_image && (r2_q > inner_q) && (r2_q < middle_q);
	assign hit2     = in_image && (r2_q > inner_q) && (r2_q >= middle_q) &&
	                  (r2_q < outer_q);
	assign sum1_nx  = {1'b0, sum1_q} + (SUM_W+1)'(sample_q);
	assign sum2_nx  = {1'b0, sum2_q} + (SUM_W+1)'(sample_q);

	assign bands_ok  = (cnt1_q != '0) && (cnt2_q != '0);
	// quotient >= 2^32 (also catches a zero denominator)
	assign ovf       = ({{FRAC_W{1'b0}}, num_q} >= {den_q, {FRAC_W{1'b0}}});
	assign div_start = (state_q == ST_CHECK) && bands_ok && !ovf;

	rbpr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	// config writes; unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q  <= '0;
			middle_q <= '0;
			outer_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INNER:  inner_q  <= cfg_data;
				CFG_MIDDLE: middle_q <= cfg_data;
				CFG_OUTER:  outer_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and band state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum1_q  <= '0;
			sum2_q  <= '0;
			cnt1_q  <= '0;
			cnt2_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) state_q <= ST_ROW;
				end
				ST_ROW:  state_q <= ST_COL;
				ST_COL:  state_q <= ST_BAND;
				ST_BAND: begin
					if (hit1) begin
						sum1_q <= sum1_nx[SUM_W] ? '1 : sum1_nx[SUM_W-1:0];
						if (cnt1_q != '1) cnt1_q <= cnt1_q + 1'b1;
					end else if (hit2) begin
						sum2_q <= sum2_nx[SUM_W] ? '1 : sum2_nx[SUM_W-1:0];
						if (cnt2_q != '1) cnt2_q <= cnt2_q + 1'b1;
					end
					state_q <= last_q ? ST_NUM_LO : ST_IDLE;
				end
				ST_NUM_LO: state_q <= ST_NUM_HI;
				ST_NUM_HI: state_q <= ST_DEN_LO;
				ST_DEN_LO: state_q <= ST_DEN_HI;
				ST_DEN_HI: state_q <= ST_CHECK;
				ST_CHECK: begin
					// products are latched; the image is done with its bands
					sum1_q  <= '0;
					sum2_q  <= '0;
					cnt1_q  <= '0;
					cnt2_q  <= '0;
					state_q <= div_start ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					if (div_stat.done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_q    <= in_item.row;
			col_q    <= in_item.col;
			sample_q <= in_item.sample_value & SAMPLE_MASK;
			last_q   <= in_item.last;
		end
		case (state_q)
			ST_ROW:    r2_q  <= mul_p[RADIUS_W-1:0];
			ST_COL:    r2_q  <= r2_q + mul_p[RADIUS_W-1:0];
			ST_NUM_LO: num_q <= PROD_W'(mul_p);
			ST_NUM_HI: num_q <= num_q + (PROD_W'(mul_p) << HALF);
			ST_DEN_LO: den_q <= PROD_W'(mul_p);
			ST_DEN_HI: den_q <= den_q + (PROD_W'(mul_p) << HALF);
			ST_CHECK: begin
				vres_q  <= bands_ok;
				ratio_q <= bands_ok ? '1 : '0;   // final unless divider runs
			end
			ST_DIV: begin
				if (div_stat.done) ratio_q <= div_quo;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_item_q.ratio     <= ratio_q;
			out_item_q.valid_res <= vres_q;
		end
	end

endmodule
